// ===== rtl/mp2c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2c_pkg - shared types and constants of the clamped 2D max pooling block
// Holds the sequencer state type, the register map, reset values and the
// fixed widths of the stream fields.
// ----------------------------------------------------------------------------
package mp2c_pkg;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_EMIT
    } t_state;

    // Field widths of the stream payloads.
    localparam int PIX_W      = 16;
    localparam int IDX_OUT_W  = 6;
    localparam int OUT_DATA_W = PIX_W + 4 * IDX_OUT_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 7;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_POOL_SIZE = 4'd0;
    localparam t_cfg_idx REG_STRIDE    = 4'd1;
    localparam t_cfg_idx REG_MAP_ROWS  = 4'd2;
    localparam t_cfg_idx REG_MAP_COLS  = 4'd3;

    // Register reset values.
    localparam logic [3:0] RST_POOL_SIZE = 4'd2;
    localparam logic [3:0] RST_STRIDE    = 4'd2;
    localparam logic [6:0] RST_MAP_ROWS  = 7'd64;
    localparam logic [6:0] RST_MAP_COLS  = 7'd64;

    // Largest stride honoured; larger values saturate.
    localparam logic [3:0] STRIDE_LIMIT = 4'd8;

endpackage

// ===== rtl/max_pool_2d_clamped.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2d_clamped - streaming 2D max pooling with edge clamping
// Stores each feature map as it arrives and, whenever a pixel completes one
// or more pooling windows, scans those windows through one read port and a
// single shared comparator, returning the maximum and its first position.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the slave stream (i_s_*) in raster order, one map after
//   another. Each pixel that is the clamped bottom-right corner of a window
//   causes one request per completed window on the master stream (o_m_*),
//   in row-major window order; tlast marks the last of them and tuser marks
//   the final window of the map.
//   Timing: each window that a pixel completes is scanned through the single
//   pixel store read port, which reads one sample per cycle into one
//   comparator, then passes a wait state and an emit state; o_s_tready
//   stays low meanwhile. A finished result sits in the output register and
//   the next window scan proceeds; only loading the following result waits
//   while the receiver stalls.
//   Configuration writes (i_cfg_*) are taken while no pixel is in work and
//   restart the map at row 0, column 0. Writes beyond the register map are
//   ignored.
//   Reset clears the position, the registers to their defaults and the
//   output valid. The pixel store is not cleared: a window only reads pixels
//   written earlier in the same map.
// ----------------------------------------------------------------------------
module max_pool_2d_clamped #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    parameter int MAX_POOL = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Pixel stream. tdata: pixel_value[15:0].
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [mp2c_pkg::PIX_W-1:0]      i_s_tdata,
    // Result stream. tdata: max_value[15:0], out_row[21:16], out_col[27:22],
    // arg_row[33:28], arg_col[39:34]. tlast: run_last. tuser: map_done.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [mp2c_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast,
    output logic                            o_m_tuser,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mp2c_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mp2c_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RW         = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW         = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW         = (RW > CW) ? RW : CW;
    localparam int XW         = ((DW > 7) ? DW : 7) + 5;
    localparam int POOL_LIMIT = (MAX_POOL < 8) ? MAX_POOL : 8;

    // Configuration registers.
    logic [3:0] r_pool_size;
    logic [3:0] r_stride;
    logic [6:0] r_map_rows;
    logic [6:0] r_map_cols;

    // Raster position and the next window candidate along each axis.
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [XW-1:0] r_ri;
    logic [XW-1:0] r_rorg;
    logic [XW-1:0] r_cj;
    logic [XW-1:0] r_corg;

    // Window loop state.
    logic [XW-1:0] r_wr_idx;
    logic [XW-1:0] r_wr_org;
    logic [XW-1:0] r_wc_idx;
    logic [XW-1:0] r_wc_org;
    logic [XW-1:0] r_cs_idx;
    logic [XW-1:0] r_cs_org;
    logic          r_multi_row;
    logic          r_multi_col;
    logic [2:0]    r_pr;
    logic [2:0]    r_pc;

    // Read pipeline and running maximum.
    logic [mp2c_pkg::PIX_W-1:0]        r_mem [DEPTH];
    logic [mp2c_pkg::PIX_W-1:0]        r_mem_q;
    logic                              r_rd_vld;
    logic                              r_rd_first;
    logic [RW-1:0]                     r_rd_row;
    logic [CW-1:0]                     r_rd_col;
    logic signed [mp2c_pkg::PIX_W-1:0] r_best;
    logic [RW-1:0]                     r_brow;
    logic [CW-1:0]                     r_bcol;

    // Output register.
    logic                                 r_out_vld;
    logic [mp2c_pkg::PIX_W-1:0]           r_out_max;
    logic [mp2c_pkg::IDX_OUT_W-1:0]       r_out_orow;
    logic [mp2c_pkg::IDX_OUT_W-1:0]       r_out_ocol;
    logic [mp2c_pkg::IDX_OUT_W-1:0]       r_out_arow;
    logic [mp2c_pkg::IDX_OUT_W-1:0]       r_out_acol;
    logic                                 r_out_last;
    logic                                 r_out_done;

    mp2c_pkg::t_state r_state;
    mp2c_pkg::t_state n_state;

    // Effective settings after clamping.
    logic [3:0]    w_pool;
    logic [3:0]    w_stride;
    logic [XW-1:0] w_pool_x;
    logic [XW-1:0] w_stride_x;
    logic [XW-1:0] w_rows;
    logic [XW-1:0] w_cols;
    logic [XW-1:0] w_rows_in;
    logic [XW-1:0] w_cols_in;

    // Window detection for the incoming pixel.
    logic [XW-1:0] w_row_x;
    logic [XW-1:0] w_col_x;
    logic          w_row_at_end;
    logic          w_col_at_end;
    logic          w_row_far_hit;
    logic          w_col_far_hit;
    logic          w_row_hit;
    logic          w_col_hit;

    // Sequencer strobes.
    logic          w_accept;
    logic          w_cfg_we;
    logic          w_issue;
    logic          w_emit;
    logic          w_last_read;
    logic          w_more_col;
    logic          w_more_row;
    logic          w_slot_free;

    // Read address generation.
    logic [XW-1:0] w_rr_raw;
    logic [XW-1:0] w_cc_raw;
    logic [RW-1:0] w_rd_row;
    logic [CW-1:0] w_rd_col;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;

    // Clamp the register values to their legal ranges.
    always_comb begin
        if (r_pool_size == 4'd0) begin
            w_pool = 4'd1;
        end else if (r_pool_size > 4'(POOL_LIMIT)) begin
            w_pool = 4'(POOL_LIMIT);
        end else begin
            w_pool = r_pool_size;
        end
        if (r_stride == 4'd0) begin
            w_stride = 4'd1;
        end else if (r_stride > mp2c_pkg::STRIDE_LIMIT) begin
            w_stride = mp2c_pkg::STRIDE_LIMIT;
        end else begin
            w_stride = r_stride;
        end
        w_rows_in = XW'(r_map_rows);
        w_cols_in = XW'(r_map_cols);
        if (w_rows_in == '0) begin
            w_rows = XW'(1);
        end else if (w_rows_in > XW'(MAX_ROWS)) begin
            w_rows = XW'(MAX_ROWS);
        end else begin
            w_rows = w_rows_in;
        end
        if (w_cols_in == '0) begin
            w_cols = XW'(1);
        end else if (w_cols_in > XW'(MAX_COLS)) begin
            w_cols = XW'(MAX_COLS);
        end else begin
            w_cols = w_cols_in;
        end
    end

    assign w_pool_x   = XW'(w_pool);
    assign w_stride_x = XW'(w_stride);

    // A window ends on this pixel along an axis when its unclamped far edge
    // is here, or, at the map edge, for every remaining window origin.
    assign w_row_x       = XW'(r_row);
    assign w_col_x       = XW'(r_col);
    assign w_row_at_end  = (w_row_x == w_rows - XW'(1));
    assign w_col_at_end  = (w_col_x == w_cols - XW'(1));
    assign w_row_far_hit = (r_rorg + w_pool_x - XW'(1) == w_row_x);
    assign w_col_far_hit = (r_corg + w_pool_x - XW'(1) == w_col_x);
    assign w_row_hit     = w_row_at_end ? (r_rorg < w_rows) : w_row_far_hit;
    assign w_col_hit     = w_col_at_end ? (r_corg < w_cols) : w_col_far_hit;

    // Further windows for the same pixel exist only at a map edge.
    assign w_more_col  = r_multi_col && (r_wc_org + w_stride_x < w_cols);
    assign w_more_row  = r_multi_row && (r_wr_org + w_stride_x < w_rows);
    assign w_last_read = ({1'b0, r_pc} == w_pool - 4'd1) && ({1'b0, r_pr} == w_pool - 4'd1);
    assign w_slot_free = !r_out_vld || i_m_tready;

    // Sequencer: next state and handshake outputs.
    always_comb begin
        n_state     = r_state;
        o_s_tready  = 1'b0;
        o_cfg_ready = 1'b0;
        w_issue     = 1'b0;
        w_emit      = 1'b0;
        case (r_state)
            mp2c_pkg::ST_IDLE: begin
                o_cfg_ready = 1'b1;
                o_s_tready  = !i_cfg_valid;
                if (i_s_tvalid && !i_cfg_valid && w_row_hit && w_col_hit) begin
                    n_state = mp2c_pkg::ST_SCAN;
                end
            end
            mp2c_pkg::ST_SCAN: begin
                w_issue = 1'b1;
                if (w_last_read) begin
                    n_state = mp2c_pkg::ST_WAIT;
                end
            end
            mp2c_pkg::ST_WAIT: begin
                n_state = mp2c_pkg::ST_EMIT;
            end
            mp2c_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    w_emit  = 1'b1;
                    n_state = (w_more_col || w_more_row) ? mp2c_pkg::ST_SCAN
                                                         : mp2c_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mp2c_pkg::ST_IDLE;
            end
        endcase
    end

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_cfg_we = i_cfg_valid && o_cfg_ready;

    // Clamped read coordinates of the current window sample.
    always_comb begin
        w_rr_raw = r_wr_org + XW'(r_pr);
        w_cc_raw = r_wc_org + XW'(r_pc);
        if (w_rr_raw > w_rows - XW'(1)) begin
            w_rd_row = RW'(w_rows - XW'(1));
        end else begin
            w_rd_row = RW'(w_rr_raw);
        end
        if (w_cc_raw > w_cols - XW'(1)) begin
            w_rd_col = CW'(w_cols - XW'(1));
        end else begin
            w_rd_col = CW'(w_cc_raw);
        end
    end

    assign w_rd_addr = AW'(int'(w_rd_row) * MAX_COLS + int'(w_rd_col));
    assign w_wr_addr = AW'(int'(r_row) * MAX_COLS + int'(r_col));

    // Pixel store: one write port for arriving pixels, one registered read.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[w_wr_addr] <= i_s_tdata;
        end
        r_mem_q <= r_mem[w_rd_addr];
    end

    // State, configuration, raster position and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mp2c_pkg::ST_IDLE;
            r_pool_size <= mp2c_pkg::RST_POOL_SIZE;
            r_stride    <= mp2c_pkg::RST_STRIDE;
            r_map_rows  <= mp2c_pkg::RST_MAP_ROWS;
            r_map_cols  <= mp2c_pkg::RST_MAP_COLS;
            r_row       <= '0;
            r_col       <= '0;
            r_ri        <= '0;
            r_rorg      <= '0;
            r_cj        <= '0;
            r_corg      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;

            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end

            // A write to a known register also restarts the map.
            if (w_cfg_we) begin
                case (i_cfg_index)
                    mp2c_pkg::REG_POOL_SIZE: r_pool_size <= i_cfg_data[3:0];
                    mp2c_pkg::REG_STRIDE:    r_stride    <= i_cfg_data[3:0];
                    mp2c_pkg::REG_MAP_ROWS:  r_map_rows  <= i_cfg_data;
                    mp2c_pkg::REG_MAP_COLS:  r_map_cols  <= i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index inside {mp2c_pkg::REG_POOL_SIZE, mp2c_pkg::REG_STRIDE,
                                        mp2c_pkg::REG_MAP_ROWS, mp2c_pkg::REG_MAP_COLS}) begin
                    r_row  <= '0;
                    r_col  <= '0;
                    r_ri   <= '0;
                    r_rorg <= '0;
                    r_cj   <= '0;
                    r_corg <= '0;
                end
            end else if (w_accept) begin
                // Advance the raster position and the window candidates.
                if (w_col_at_end) begin
                    r_col  <= '0;
                    r_cj   <= '0;
                    r_corg <= '0;
                    if (w_row_at_end) begin
                        r_row  <= '0;
                        r_ri   <= '0;
                        r_rorg <= '0;
                    end else begin
                        r_row <= r_row + RW'(1);
                        if (w_row_far_hit) begin
                            r_ri   <= r_ri + XW'(1);
                            r_rorg <= r_rorg + w_stride_x;
                        end
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                    if (w_col_far_hit) begin
                        r_cj   <= r_cj + XW'(1);
                        r_corg <= r_corg + w_stride_x;
                    end
                end
            end
        end
    end

    // Window loop and sample counters.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_wr_idx    <= r_ri;
            r_wr_org    <= r_rorg;
            r_wc_idx    <= r_cj;
            r_wc_org    <= r_corg;
            r_cs_idx    <= r_cj;
            r_cs_org    <= r_corg;
            r_multi_row <= w_row_at_end;
            r_multi_col <= w_col_at_end;
            r_pr        <= '0;
            r_pc        <= '0;
        end else if (w_issue) begin
            if ({1'b0, r_pc} == w_pool - 4'd1) begin
                r_pc <= '0;
                r_pr <= r_pr + 3'd1;
            end else begin
                r_pc <= r_pc + 3'd1;
            end
        end else if (w_emit) begin
            r_pr <= '0;
            r_pc <= '0;
            if (w_more_col) begin
                r_wc_idx <= r_wc_idx + XW'(1);
                r_wc_org <= r_wc_org + w_stride_x;
            end else if (w_more_row) begin
                r_wr_idx <= r_wr_idx + XW'(1);
                r_wr_org <= r_wr_org + w_stride_x;
                r_wc_idx <= r_cs_idx;
                r_wc_org <= r_cs_org;
            end
        end
    end

    // Read tags are registered alongside the store read data.
    always_ff @(posedge i_clk) begin
        r_rd_first <= (r_pr == 3'd0) && (r_pc == 3'd0);
        r_rd_row   <= w_rd_row;
        r_rd_col   <= w_rd_col;
    end

    // Shared comparator: the first sample seeds the maximum, later ones
    // replace it only when strictly greater.
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (r_rd_first || ($signed(r_mem_q) > r_best)) begin
                r_best <= $signed(r_mem_q);
                r_brow <= r_rd_row;
                r_bcol <= r_rd_col;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_max  <= r_best;
            r_out_orow <= mp2c_pkg::IDX_OUT_W'(r_wr_idx);
            r_out_ocol <= mp2c_pkg::IDX_OUT_W'(r_wc_idx);
            r_out_arow <= mp2c_pkg::IDX_OUT_W'(r_brow);
            r_out_acol <= mp2c_pkg::IDX_OUT_W'(r_bcol);
            r_out_last <= !(w_more_col || w_more_row);
            r_out_done <= (r_wr_org + w_stride_x >= w_rows) &&
                          (r_wc_org + w_stride_x >= w_cols);
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_acol, r_out_arow, r_out_ocol, r_out_orow, r_out_max};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_done;

`ifndef ASSERT_OFF
    // Store reads are only in flight while a window is being scanned.
    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == mp2c_pkg::ST_SCAN || r_state == mp2c_pkg::ST_WAIT))
        else $error("store read outstanding outside a window scan");

    // The final window of a map is always the last result of its pixel.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("map end flagged on a result that is not last");

    // A finished window waits while the output register is held.
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mp2c_pkg::ST_EMIT && r_out_vld && !i_m_tready)
        |=> (r_state == mp2c_pkg::ST_EMIT))
        else $error("window result left while output stalled");

    // Sample counters stay inside the window.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mp2c_pkg::ST_SCAN) |-> ({1'b0, r_pr} < w_pool && {1'b0, r_pc} < w_pool))
        else $error("window sample counter out of range");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the clamped 2D max pooling block
// Streams feature maps into the block under many register settings and
// checks every result request against a predictor that keeps its own copy
// of the stored map, the raster position and the registers. Both stream
// sides pause at random, and the run includes one long receiver stall and
// one sender pause within a map until all outstanding windows have returned.
// ----------------------------------------------------------------------------
module tb_top;
    import mp2c_pkg::*;

    localparam int ROWS_LIMIT     = 64;
    localparam int COLS_LIMIT     = 64;
    localparam int POOL_LIMIT     = 8;
    localparam int ITEM_TARGET    = 470;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam t_cfg_idx FIRST_UNUSED_REG = REG_MAP_COLS + 1;
    localparam t_cfg_idx LAST_REG_INDEX   = {CFG_IDX_W{1'b1}};

    // One pooled window as it should leave the block.
    typedef struct {
        logic [PIX_W-1:0]     max_value;
        logic [IDX_OUT_W-1:0] out_row;
        logic [IDX_OUT_W-1:0] out_col;
        logic [IDX_OUT_W-1:0] arg_row;
        logic [IDX_OUT_W-1:0] arg_col;
        logic                 run_last;
        logic                 map_done;
    } pooled_t;

    // Predicts pooled windows from accepted pixels and checks the results.
    class pool_window_ledger;
        logic signed [PIX_W-1:0] samples [ROWS_LIMIT*COLS_LIMIT];
        int unsigned             pos_row;
        int unsigned             pos_col;
        logic [3:0]              pool_reg;
        logic [3:0]              stride_reg;
        logic [6:0]              rows_reg;
        logic [6:0]              cols_reg;
        pooled_t                 expected_windows[$];
        int                      mismatches;
        int                      results_seen;

        function new();
            pos_row      = 0;
            pos_col      = 0;
            pool_reg     = RST_POOL_SIZE;
            stride_reg   = RST_STRIDE;
            rows_reg     = RST_MAP_ROWS;
            cols_reg     = RST_MAP_COLS;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        static function int unsigned bounded(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        // A register write restarts the map unless the index is unused.
        function void take_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_POOL_SIZE: pool_reg   = value[3:0];
                REG_STRIDE:    stride_reg = value[3:0];
                REG_MAP_ROWS:  rows_reg   = value;
                REG_MAP_COLS:  cols_reg   = value;
                default: return;
            endcase
            pos_row = 0;
            pos_col = 0;
        endfunction

        // Indices of the windows along one axis whose clamped far edge lies at pos.
        function int closing_origins(int unsigned pos, int unsigned len,
                                     int unsigned s, int unsigned p,
                                     output int unsigned org[8]);
            int unsigned n;
            int unsigned far_edge;
            int unsigned i;
            int          cnt;
            n   = (len + s - 1) / s;
            cnt = 0;
            for (i = 0; i < n; i++) begin
                far_edge = i * s + p - 1;
                if (far_edge > len - 1) far_edge = len - 1;
                if (far_edge == pos && cnt < 8) begin
                    org[cnt] = i;
                    cnt++;
                end
            end
            return cnt;
        endfunction

        // Stores the pixel and queues every window it completes.
        function void take_pixel(logic [PIX_W-1:0] value);
            int unsigned             p, s, rows, cols, nr, nc, r, c;
            int unsigned             row_org[8];
            int unsigned             col_org[8];
            int                      ni, nj, a, b;
            int unsigned             r0, c0, rr, cc, br, bc, pr, pc;
            logic signed [PIX_W-1:0] best;
            pooled_t                 w;
            p    = bounded(pool_reg, POOL_LIMIT);
            s    = bounded(stride_reg, STRIDE_LIMIT);
            rows = bounded(rows_reg, ROWS_LIMIT);
            cols = bounded(cols_reg, COLS_LIMIT);
            nr   = (rows + s - 1) / s;
            nc   = (cols + s - 1) / s;
            if (pos_row >= rows) pos_row = 0;
            if (pos_col >= cols) pos_col = 0;
            r = pos_row;
            c = pos_col;
            samples[r * COLS_LIMIT + c] = value;
            ni = closing_origins(r, rows, s, p, row_org);
            nj = closing_origins(c, cols, s, p, col_org);
            for (a = 0; a < ni; a++) begin
                for (b = 0; b < nj; b++) begin
                    r0   = row_org[a] * s;
                    c0   = col_org[b] * s;
                    best = samples[r0 * COLS_LIMIT + c0];
                    br   = r0;
                    bc   = c0;
                    // Row-major scan; only a strictly greater sample moves the maximum.
                    for (pr = 0; pr < p; pr++) begin
                        rr = (r0 + pr > rows - 1) ? rows - 1 : r0 + pr;
                        for (pc = 0; pc < p; pc++) begin
                            cc = (c0 + pc > cols - 1) ? cols - 1 : c0 + pc;
                            if (samples[rr * COLS_LIMIT + cc] > best) begin
                                best = samples[rr * COLS_LIMIT + cc];
                                br   = rr;
                                bc   = cc;
                            end
                        end
                    end
                    w.max_value = best;
                    w.out_row   = IDX_OUT_W'(row_org[a]);
                    w.out_col   = IDX_OUT_W'(col_org[b]);
                    w.arg_row   = IDX_OUT_W'(br);
                    w.arg_col   = IDX_OUT_W'(bc);
                    w.run_last  = (a == ni - 1) && (b == nj - 1);
                    w.map_done  = (row_org[a] == nr - 1) && (col_org[b] == nc - 1);
                    expected_windows = {expected_windows, w};
                end
            end
            pos_col = c + 1;
            if (pos_col >= cols) begin
                pos_col = 0;
                pos_row = (r + 1 >= rows) ? 0 : r + 1;
            end
        endfunction

        task report_mismatch(string what);
            $display("[%0t] result %0d: %s", $time, results_seen, what);
            mismatches++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
        endtask

        // Checks one accepted result request against the oldest prediction.
        task check_window(logic [OUT_DATA_W-1:0] data, logic last, logic user);
            pooled_t w;
            results_seen++;
            if (expected_windows.size() == 0) begin
                report_mismatch($sformatf("unpredicted result, tdata %h", data));
                return;
            end
            w = expected_windows.pop_front();
            compare_field("max_value", data[0 +: PIX_W], w.max_value);
            compare_field("out_row", data[PIX_W +: IDX_OUT_W], w.out_row);
            compare_field("out_col", data[PIX_W + IDX_OUT_W +: IDX_OUT_W], w.out_col);
            compare_field("arg_row", data[PIX_W + 2*IDX_OUT_W +: IDX_OUT_W], w.arg_row);
            compare_field("arg_col", data[PIX_W + 3*IDX_OUT_W +: IDX_OUT_W], w.arg_col);
            compare_field("run_last", last, w.run_last);
            compare_field("map_done", user, w.map_done);
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  pix_valid = 1'b0;
    logic                  pix_ready;
    logic [PIX_W-1:0]      pix_data = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    logic [OUT_DATA_W-1:0] res_data;
    logic                  res_last;
    logic                  res_user;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    t_cfg_idx              cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pool_window_ledger ledger;
    int                items_sent = 0;
    int                src_gap_max = 15;
    int                snk_gap_max = 15;
    int                holds_asked = 0;
    int                holds_done = 0;
    int                quiet_cycles = 0;

    max_pool_2d_clamped dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (pix_valid),
        .o_s_tready  (pix_ready),
        .i_s_tdata   (pix_data),
        .o_m_tvalid  (res_valid),
        .i_m_tready  (res_ready),
        .o_m_tdata   (res_data),
        .o_m_tlast   (res_last),
        .o_m_tuser   (res_user),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Mixes extreme values and a narrow band that produces ties with full-range samples.
    function automatic logic [PIX_W-1:0] next_sample();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            1, 2: return PIX_W'($urandom_range(0, 4)) - PIX_W'(2);
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Offers one pixel request after a random gap and waits for its acceptance.
    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= value;
        do @(posedge i_clk); while (!pix_ready);
        ledger.take_pixel(value);
        items_sent++;
    endtask

    task automatic stream_samples(input int count);
        repeat (count) send_pixel(next_sample());
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        ledger.take_register(idx, value);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Upper data bits of the 4-bit registers are noise that must be dropped.
    task automatic configure(input int pool, input int stride, input int rows, input int cols);
        write_register(REG_POOL_SIZE, {3'($urandom), 4'(pool)});
        write_register(REG_STRIDE, {3'($urandom), 4'(stride)});
        write_register(REG_MAP_ROWS, CFG_DATA_W'(rows));
        write_register(REG_MAP_COLS, CFG_DATA_W'(cols));
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        pix_valid <= 1'b0;
        while (ledger.expected_windows.size() != 0) @(posedge i_clk);
    endtask

    // Leaves the block idle: all windows returned and any last pixel retired.
    task automatic settle();
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase();
        int pool, stride, rows, cols, rows_eff, cols_eff, area, count;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: pool = $urandom_range(1, 4);
            6, 7:             pool = $urandom_range(5, 8);
            8:                pool = 0;
            default:          pool = $urandom_range(9, 15);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: stride = $urandom_range(1, 3);
            7, 8:                stride = $urandom_range(4, 8);
            default:             stride = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
        endcase
        case ($urandom_range(0, 9))
            0:       rows = 0;
            1:       rows = $urandom_range(64, 127);
            default: rows = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 9))
            0:       cols = 0;
            1:       cols = $urandom_range(64, 127);
            default: cols = $urandom_range(1, 8);
        endcase
        rows_eff = (rows == 0) ? 1 : (rows > ROWS_LIMIT) ? ROWS_LIMIT : rows;
        cols_eff = (cols == 0) ? 1 : (cols > COLS_LIMIT) ? COLS_LIMIT : cols;
        area     = rows_eff * cols_eff;
        if ($urandom_range(0, 2) == 0)
            write_register(t_cfg_idx'($urandom_range(FIRST_UNUSED_REG, LAST_REG_INDEX)),
                           CFG_DATA_W'($urandom));
        src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
        snk_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
        configure(pool, stride, rows, cols);
        // Large maps are cut short; a partial map is restarted by the next phase.
        if (area > 60) begin
            count = $urandom_range(8, 60);
        end else begin
            case ($urandom_range(0, 3))
                0:       count = $urandom_range(1, area);
                1:       count = 2 * area;
                default: count = area;
            endcase
        end
        // The final phase stops at the item target.
        if (count > ITEM_TARGET - items_sent)
            count = ITEM_TARGET - items_sent;
        stream_samples(count);
        settle();
    endtask

    // Result side: random stalls per request, plus one long hold when asked.
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            if (holds_asked != holds_done) begin
                holds_done++;
                @(negedge i_clk);
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            gap = $urandom_range(0, snk_gap_max);
            @(negedge i_clk);
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ready <= 1'b1;
            do @(posedge i_clk); while (!res_valid);
            ledger.check_window(res_data, res_last, res_user);
        end
    end

    // Ends the run when no request of any kind has moved for too long.
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((pix_valid && pix_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        ledger = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero pool and stride act as 1; zero rows act as a single row.
        configure(0, 0, 0, 3);
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        send_pixel(16'h0000);
        settle();

        // Oversized pool and stride saturate; tied maxima keep the first position.
        configure(12, 11, 2, 2);
        send_pixel(16'd7);
        send_pixel(16'd7);
        send_pixel(16'h8000);
        send_pixel(16'd7);
        settle();

        // A write to an unused index must not restart the map.
        write_register(FIRST_UNUSED_REG, CFG_DATA_W'($urandom));

        // Stride beyond the pool: the map's last pixel closes no window.
        configure(1, 3, 2, 2);
        send_pixel(-16'sd1);
        send_pixel(16'd1);
        send_pixel(16'd2);
        send_pixel(-16'sd2);
        settle();

        // Clamped overlapping windows all close on the final pixel.
        configure(2, 1, 2, 2);
        send_pixel(16'd5);
        send_pixel(16'd9);
        send_pixel(16'd9);
        send_pixel(16'd3);
        settle();

        // Largest pool with unit stride: 64 windows close on one pixel.
        configure(8, 1, 8, 8);
        stream_samples(64);
        settle();

        // Saturated row count, one column; the receiver holds off meanwhile.
        holds_asked++;
        configure(1, 1, 127, 1);
        stream_samples(64);
        settle();

        // Widest single row at the largest stride, with a pause half way.
        configure(3, 8, 1, 64);
        stream_samples(32);
        pause_until_drained();
        stream_samples(32);
        settle();

        while (items_sent < ITEM_TARGET) random_phase();
        settle();

        while (ledger.expected_windows.size() != 0) begin
            void'(ledger.expected_windows.pop_front());
            ledger.report_mismatch("predicted window never returned");
        end
        if (ledger.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
